FILE: rtl/core/ebd_pkg.sv
// ----------------------------------------------------------------------------
// Energy beat detector package
// Widths, register map and shared types for the energy beat detector.
// ----------------------------------------------------------------------------
package ebd_pkg;

   // Window depth and volume width.
   localparam int MAX_HISTORY = 16;
   localparam int VOL_BITS    = 20;

   // Fill count holds 0 .. MAX_HISTORY; the sum holds MAX_HISTORY volumes.
   localparam int FILL_BITS = $clog2(MAX_HISTORY + 1);
   localparam int SUM_BITS  = VOL_BITS + FILL_BITS;

   // Register and field widths.
   localparam int LEN_BITS   = 5;
   localparam int THR_BITS   = 12;
   localparam int TIME_BITS  = 16;
   localparam int OUT_BITS   = 24;
   localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // Cross-multiplied comparison operands.
   localparam int LHS_BITS  = VOL_BITS + FILL_BITS + 8;
   localparam int RHS_BITS  = SUM_BITS + THR_BITS;
   localparam int PROD_BITS = (LHS_BITS > RHS_BITS) ? LHS_BITS : RHS_BITS;

   // Stream packing.
   localparam int REQ_FIELD_BITS = VOL_BITS + TIME_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((OUT_BITS + 7) / 8) * 8;

   // Register bus.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_HISTORY_LEN = 2'd0;
   localparam logic [1:0] REG_THRESHOLD   = 2'd1;
   localparam logic [1:0] REG_HOLDOFF     = 2'd2;

   // Window state after the push of the current request.
   typedef struct packed {
      logic [SUM_BITS-1:0]  sum;
      logic [FILL_BITS-1:0] filled;
   } win_status_type;

endpackage

FILE: rtl/core/energy_beat_detector.sv
// ----------------------------------------------------------------------------
// Energy beat detector
// Moving-average beat detection over a window of recent block volumes.
// ----------------------------------------------------------------------------
// Each request on the req_ stream carries one block volume and the
// milliseconds since the previous request. The volume shifts into a chain of
// history cells, the running sum is updated, and a beat is flagged when the
// volume times the fill level times 256 exceeds the sum times threshold_q8
// and more than holdoff_ms has passed since the previous beat.
// Exactly one result per request leaves on the rsp_ stream: tuser holds the
// beat flag, tdata the saturated window sum.
// Throughput is one request per cycle while the receiver takes results; the
// window update, both products and the timer are evaluated in the accept
// cycle. The output register raises rsp_tvalid in the cycle after accept.
// When the receiver stalls, the output register holds its result and
// req_tready drops until it is taken; a new request is accepted in the same
// cycle a waiting result leaves.
// Reset is synchronous: the window empties, the beat timer clears and the
// registers return to history_len 5, threshold_q8 384, holdoff_ms 300.
// The user must write registers through the csr_ port only while idle.
// ----------------------------------------------------------------------------
module energy_beat_detector import ebd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Request stream. tdata: volume [19:0], elapsed_ms [35:20], zero pad.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // Result stream. tdata: window_sum [23:0]. tuser: beat [0].
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tuser,
   // Register bus.
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [LEN_BITS-1:0]  history_len_ff;
   logic [THR_BITS-1:0]  threshold_ff;
   logic [TIME_BITS-1:0] holdoff_ff;
   logic                 csr_write;
   logic [1:0]           csr_index;

   logic                 accept;
   logic [VOL_BITS-1:0]  volume;
   logic [TIME_BITS-1:0] elapsed_ms;
   win_status_type       status;

   logic [TIME_BITS:0]   time_sum;
   logic [TIME_BITS-1:0] time_sat;
   logic [LHS_BITS-1:0]  lhs;
   logic [RHS_BITS-1:0]  rhs;
   logic                 beat;
   logic [OUT_BITS-1:0]  sum_out;

   logic [TIME_BITS-1:0] since_beat_ff;
   logic [TIME_BITS-1:0] since_beat_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_beat_ff;
   logic [OUT_BITS-1:0]  rsp_sum_ff;

   // Register bus: writes complete in the access phase, reads are plain muxes.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         history_len_ff <= LEN_BITS'(5);
         threshold_ff   <= THR_BITS'(384);
         holdoff_ff     <= TIME_BITS'(300);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_HISTORY_LEN: history_len_ff <= csr_pwdata[LEN_BITS-1:0];
            REG_THRESHOLD:   threshold_ff   <= csr_pwdata[THR_BITS-1:0];
            REG_HOLDOFF:     holdoff_ff     <= csr_pwdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_HISTORY_LEN: csr_prdata = CSR_DATA_BITS'(history_len_ff);
         REG_THRESHOLD:   csr_prdata = CSR_DATA_BITS'(threshold_ff);
         REG_HOLDOFF:     csr_prdata = CSR_DATA_BITS'(holdoff_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // A request is taken whenever the output register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign volume     = req_tdata[VOL_BITS-1:0];
   assign elapsed_ms = req_tdata[VOL_BITS +: TIME_BITS];

   ebd_window u_window (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .volume      (volume),
      .history_len (history_len_ff),
      .status      (status)
   );

   // Beat timer saturates before the holdoff test.
   assign time_sum = {1'b0, since_beat_ff} + {1'b0, elapsed_ms};
   assign time_sat = time_sum[TIME_BITS] ? TIME_MAX : time_sum[TIME_BITS-1:0];

   // Volume against the scaled average, cross-multiplied.
   assign lhs = {LHS_BITS'(volume) * LHS_BITS'(status.filled)} << 8;
   assign rhs = RHS_BITS'(status.sum) * RHS_BITS'(threshold_ff);

   assign beat = (PROD_BITS'(lhs) > PROD_BITS'(rhs)) && (time_sat > holdoff_ff);

   assign since_beat_in = !accept ? since_beat_ff : (beat ? '0 : time_sat);

   // Window sum clipped to the field width.
   always_comb begin
      if (64'(status.sum) > 64'(OUT_MAX)) begin
         sum_out = OUT_MAX;
      end else begin
         sum_out = OUT_BITS'(status.sum);
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         since_beat_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         since_beat_ff <= since_beat_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload loads on accept and holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_beat_ff <= beat;
         rsp_sum_ff  <= sum_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_beat_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_sum_ff);

endmodule

FILE: rtl/core/ebd_cell.sv
// ----------------------------------------------------------------------------
// Energy beat detector history cell
// One slot of the volume shift line with its share of the oldest-entry tap.
// ----------------------------------------------------------------------------
module ebd_cell import ebd_pkg::*; (
   input  logic                clock,
   input  logic                push,
   input  logic [VOL_BITS-1:0] shift_vol,
   input  logic                oldest_sel,
   input  logic [VOL_BITS-1:0] acc_prev,
   output logic [VOL_BITS-1:0] vol_out,
   output logic [VOL_BITS-1:0] acc_next
);

   logic [VOL_BITS-1:0] vol_ff;
   logic [VOL_BITS-1:0] vol_in;

   // Take the neighbor's volume on every push.
   assign vol_in = push ? shift_vol : vol_ff;

   always_ff @(posedge clock) begin
      vol_ff <= vol_in;
   end

   // Merge this cell's volume into the tap chain when it is the oldest one.
   assign acc_next = acc_prev | (oldest_sel ? vol_ff : '0);
   assign vol_out  = vol_ff;

endmodule

FILE: rtl/core/ebd_window.sv
// ----------------------------------------------------------------------------
// Energy beat detector window
// Chain of history cells with fill count and running sum.
// ----------------------------------------------------------------------------
module ebd_window import ebd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [VOL_BITS-1:0]  volume,
   input  logic [LEN_BITS-1:0]  history_len,
   output win_status_type       status
);

   logic [VOL_BITS-1:0]  vol_chain [MAX_HISTORY+1];
   logic [VOL_BITS-1:0]  acc_chain [MAX_HISTORY+1];
   logic [FILL_BITS-1:0] filled_ff;
   logic [FILL_BITS-1:0] filled_in;
   logic [SUM_BITS-1:0]  sum_ff;
   logic [SUM_BITS-1:0]  sum_in;
   logic [FILL_BITS-1:0] len_eff;
   logic                 evict;
   logic [SUM_BITS-1:0]  evict_vol;

   // Cell 0 holds the newest volume; cell k the one pushed k requests ago.
   assign vol_chain[0] = volume;
   assign acc_chain[0] = '0;

   for (genvar k = 0; k < MAX_HISTORY; k++) begin : g_cell
      ebd_cell u_cell (
         .clock      (clock),
         .push       (push),
         .shift_vol  (vol_chain[k]),
         .oldest_sel (filled_ff == FILL_BITS'(k + 1)),
         .acc_prev   (acc_chain[k]),
         .vol_out    (vol_chain[k+1]),
         .acc_next   (acc_chain[k+1])
      );
   end

   // Window length clamped to 1 .. MAX_HISTORY.
   always_comb begin
      if (history_len == '0) begin
         len_eff = FILL_BITS'(1);
      end else if (32'(history_len) > 32'(MAX_HISTORY)) begin
         len_eff = FILL_BITS'(MAX_HISTORY);
      end else begin
         len_eff = FILL_BITS'(history_len);
      end
   end

   // A full window drops exactly one oldest volume per push.
   assign evict     = (filled_ff >= len_eff) && (filled_ff != '0);
   assign evict_vol = evict ? SUM_BITS'(acc_chain[MAX_HISTORY]) : '0;

   always_comb begin
      status.sum    = sum_ff - evict_vol + SUM_BITS'(volume);
      status.filled = evict ? filled_ff : filled_ff + FILL_BITS'(1);
   end

   assign sum_in    = push ? status.sum : sum_ff;
   assign filled_in = push ? status.filled : filled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         filled_ff <= '0;
      end else begin
         sum_ff    <= sum_in;
         filled_ff <= filled_in;
      end
   end

endmodule

FILE: dv/energy_beat_detector_tb.sv
// ----------------------------------------------------------------------------
// Energy beat detector testbench
// Drives block volumes and elapsed times into the detector through its request
// stream and checks every beat flag and window sum against a local model of
// the moving-average window or typed-in results. A short table of hand-picked
// requests and register writes comes first. Several register settings with
// shaped random traffic follow, with random idle gaps on the request side and
// random stalls on the result side.
// ----------------------------------------------------------------------------
module energy_beat_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ebd_pkg::*;

   localparam int unsigned VOL_MAX     = (1 << VOL_BITS) - 1;
   localparam int          SLOT_BITS   = $clog2(MAX_HISTORY);
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          PHASES      = 8;
   localparam int          PHASE_ITEMS = 213;
   localparam int          PEND_DEPTH  = 64;
   localparam int          PEND_BITS   = $clog2(PEND_DEPTH);

   // One row of the directed table: either a request or a register write.
   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [1:0]               reg_idx;
      logic [CSR_DATA_BITS-1:0] wdata;
      logic [VOL_BITS-1:0]      vol;
      logic [TIME_BITS-1:0]     elapsed;
      logic                     fixed;
      logic                     beat;
      logic [OUT_BITS-1:0]      sum;
   } dir_row_type;

   typedef struct packed {
      logic                beat;
      logic [OUT_BITS-1:0] sum;
   } beat_result_type;

   localparam int DIR_ROWS = 26;

   // Fixed results are typed in only for the opening rows under reset settings.
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd1000,    16'd0,     1'b1, 1'b0, 24'd1000},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'hFFFFF,   16'hFFFF,  1'b1, 1'b1, 24'd1049575},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd0,       16'd0,     1'b1, 1'b0, 24'd1049575},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd0,       16'hFFFF,  1'b1, 1'b0, 24'd1049575},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'hFFFFF,   16'hFFFF,  1'b1, 1'b1, 24'd2098150},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd1,       16'd100,   1'b1, 1'b0, 24'd2097151},
      '{ROW_CSR, REG_THRESHOLD, 32'd0, 20'd0,  16'd0,     1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd0,       16'd400,   1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd5,       16'd0,     1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd5,       16'd299,   1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd5,       16'd1,     1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd5,       16'd1,     1'b0, 1'b0, 24'd0},
      '{ROW_CSR, REG_HOLDOFF, 32'd65535, 20'd0, 16'd0,    1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'hFFFFF,   16'hFFFF,  1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'hFFFFF,   16'hFFFF,  1'b0, 1'b0, 24'd0},
      '{ROW_CSR, REG_HOLDOFF, 32'd0, 20'd0,    16'd0,     1'b0, 1'b0, 24'd0},
      '{ROW_CSR, REG_THRESHOLD, 32'd4095, 20'd0, 16'd0,   1'b0, 1'b0, 24'd0},
      '{ROW_CSR, REG_HISTORY_LEN, 32'd0, 20'd0, 16'd0,    1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd7,       16'd1,     1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd9,       16'd1,     1'b0, 1'b0, 24'd0},
      '{ROW_CSR, REG_HISTORY_LEN, 32'd31, 20'd0, 16'd0,   1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'hFFFFF,   16'hFFFF,  1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd123456,  16'd32768, 1'b0, 1'b0, 24'd0},
      '{ROW_CSR, REG_HISTORY_LEN, 32'd2, 20'd0, 16'd0,    1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'd1,       16'd1,     1'b0, 1'b0, 24'd0},
      '{ROW_REQUEST, 2'd0, 32'd0, 20'hFFFFF,   16'd0,     1'b0, 1'b0, 24'd0}
   };

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // volume [19:0], elapsed_ms [35:20], zero pad
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // window_sum [23:0]
   logic                     rsp_tuser;   // beat [0]
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Typed-in result riding along with the request currently offered.
   logic                req_fixed;
   logic                req_fixed_beat;
   logic [OUT_BITS-1:0] req_fixed_sum;

   // Local copy of the registers and of the window state.
   logic [LEN_BITS-1:0]  cfg_len  = LEN_BITS'(5);
   logic [THR_BITS-1:0]  cfg_thr  = THR_BITS'(384);
   logic [TIME_BITS-1:0] cfg_hold = TIME_BITS'(300);
   logic [VOL_BITS-1:0]  win_vol [MAX_HISTORY];
   logic [SLOT_BITS-1:0] win_slot = '0;
   logic [FILL_BITS-1:0] win_fill = '0;
   logic [SUM_BITS-1:0]  win_sum  = '0;
   logic [TIME_BITS-1:0] quiet_ms = '0;

   // Expected results in request order, kept in a small ring.
   beat_result_type      pend_buf [PEND_DEPTH];
   logic [PEND_BITS-1:0] pend_wr = '0;
   logic [PEND_BITS-1:0] pend_rd = '0;
   int                   pend_count = 0;

   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           stall_left = 0;

   energy_beat_detector uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[energy_beat_detector] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40)
         $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         return $urandom_range(1, 3);
      else if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] field_mask(input logic [1:0] idx);
      case (idx)
         REG_HISTORY_LEN: return (1 << LEN_BITS) - 1;
         REG_THRESHOLD:   return (1 << THR_BITS) - 1;
         default:         return (1 << TIME_BITS) - 1;
      endcase
   endfunction

   // Push one volume into the window and decide on a beat.
   function automatic beat_result_type predict_window(input logic [VOL_BITS-1:0] vol,
                                                      input logic [TIME_BITS-1:0] elapsed);
      logic [FILL_BITS-1:0] eff_len;
      logic [SLOT_BITS-1:0] oldest;
      logic [TIME_BITS:0]   timer;
      logic [63:0]          lhs;
      logic [63:0]          rhs;
      beat_result_type      res;
      if (cfg_len == 0)
         eff_len = FILL_BITS'(1);
      else if (cfg_len > MAX_HISTORY)
         eff_len = FILL_BITS'(MAX_HISTORY);
      else
         eff_len = cfg_len;
      // Evict the oldest volume once the window is full; a shrunken window
      // only loses one entry per push.
      if (win_fill >= eff_len && win_fill > 0) begin
         oldest = win_slot - win_fill[SLOT_BITS-1:0];
         win_sum = win_sum - win_vol[oldest];
         win_fill = FILL_BITS'(win_fill - 1);
      end
      win_vol[win_slot] = vol;
      win_slot = SLOT_BITS'(win_slot + 1);
      win_sum = win_sum + vol;
      win_fill = FILL_BITS'(win_fill + 1);
      // The beat timer saturates before the holdoff test.
      timer = {1'b0, quiet_ms} + elapsed;
      quiet_ms = timer[TIME_BITS] ? TIME_MAX : timer[TIME_BITS-1:0];
      lhs = vol * win_fill * 64'd256;
      rhs = win_sum * cfg_thr;
      res.beat = (lhs > rhs) && (quiet_ms > cfg_hold);
      if (res.beat)
         quiet_ms = '0;
      res.sum = (win_sum > OUT_MAX) ? OUT_MAX : win_sum[OUT_BITS-1:0];
      return res;
   endfunction

   // Predict on every accepted request, then check every accepted result.
   always @(posedge clock) begin
      beat_result_type pred;
      beat_result_type want;
      if (!reset && req_tvalid && req_tready) begin
         pred = predict_window(req_tdata[VOL_BITS-1:0], req_tdata[VOL_BITS +: TIME_BITS]);
         if (req_fixed) begin
            pred.beat = req_fixed_beat;
            pred.sum = req_fixed_sum;
         end
         if (pend_count == PEND_DEPTH) begin
            report_mismatch("too many results pending");
         end else begin
            pend_buf[pend_wr] = pred;
            pend_wr = pend_wr + 1'b1;
            pend_count++;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pend_count == 0) begin
            report_mismatch($sformatf("result with nothing pending: beat %0b sum %0d",
                                      rsp_tuser, rsp_tdata[OUT_BITS-1:0]));
         end else begin
            want = pend_buf[pend_rd];
            pend_rd = pend_rd + 1'b1;
            pend_count--;
            if (rsp_tuser !== want.beat)
               report_mismatch($sformatf("beat %0b, expected %0b", rsp_tuser, want.beat));
            if (rsp_tdata[OUT_BITS-1:0] !== want.sum)
               report_mismatch($sformatf("window sum %0d, expected %0d",
                                         rsp_tdata[OUT_BITS-1:0], want.sum));
         end
      end
      // Result side backpressure.
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
         stall_left = idle_length() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one request and hold it until the handshake completes.
   task automatic send_request(input logic [VOL_BITS-1:0] vol,
                               input logic [TIME_BITS-1:0] elapsed,
                               input logic fixed, input logic fixed_beat,
                               input logic [OUT_BITS-1:0] fixed_sum);
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_BITS - REQ_FIELD_BITS){1'b0}}, elapsed, vol};
      req_fixed <= fixed;
      req_fixed_beat <= fixed_beat;
      req_fixed_sum <= fixed_sum;
      do @(posedge clock); while (!req_tready);
   endtask

   // Random idle gap after a request, with junk on the data lines.
   task automatic pause_sender();
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= REQ_DATA_BITS'({$urandom(), $urandom()});
         repeat (idle_length()) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every pending result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pend_count != 0);
      repeat (2) @(posedge clock);
   endtask

   // Register write followed by a read back; the local copy follows the write.
   task automatic write_register(input logic [1:0] idx, input logic [CSR_DATA_BITS-1:0] wdata);
      logic [CSR_DATA_BITS-1:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_HISTORY_LEN: cfg_len = wdata[LEN_BITS-1:0];
         REG_THRESHOLD:   cfg_thr = wdata[THR_BITS-1:0];
         default:         cfg_hold = wdata[TIME_BITS-1:0];
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_pwdata <= $urandom();
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== (wdata & field_mask(idx)))
         report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                   idx, got, wdata & field_mask(idx)));
   endtask

   initial begin : stimulus
      int unsigned vol32;
      int unsigned base;
      int          pick;
      logic [TIME_BITS-1:0]     elapsed;
      logic [LEN_BITS-1:0]      new_len;
      logic [THR_BITS-1:0]      new_thr;
      logic [TIME_BITS-1:0]     new_hold;
      logic [CSR_DATA_BITS-1:0] junk;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_fixed = 1'b0;
      req_fixed_beat = 1'b0;
      req_fixed_sum = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      send_idle_pct = 30;
      recv_stall_pct = 30;
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain_results();
            write_register(dir_rows[i].reg_idx, dir_rows[i].wdata);
         end else begin
            send_request(dir_rows[i].vol, dir_rows[i].elapsed, dir_rows[i].fixed,
                         dir_rows[i].beat, dir_rows[i].sum);
            pause_sender();
         end
      end

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0: begin
               new_len = LEN_BITS'(16);
               new_thr = THR_BITS'(384);
               new_hold = TIME_BITS'(300);
            end
            1: begin
               new_len = LEN_BITS'(1);
               new_thr = '0;
               new_hold = '0;
            end
            2: begin
               new_len = LEN_BITS'(31);
               new_thr = THR_BITS'(4095);
               new_hold = TIME_BITS'(65535);
            end
            3: begin
               // Window shrinks well below its current fill.
               new_len = LEN_BITS'(2);
               new_thr = THR_BITS'($urandom_range(256, 768));
               new_hold = TIME_BITS'($urandom_range(0, 400));
            end
            default: begin
               new_len = LEN_BITS'($urandom_range(0, 31));
               new_thr = ($urandom_range(0, 3) == 0) ? THR_BITS'($urandom())
                                                     : THR_BITS'($urandom_range(256, 1024));
               new_hold = ($urandom_range(0, 3) == 0) ? TIME_BITS'($urandom())
                                                      : TIME_BITS'($urandom_range(0, 600));
            end
         endcase
         junk = $urandom();
         write_register(REG_HISTORY_LEN,
                        (junk & ~field_mask(REG_HISTORY_LEN)) | CSR_DATA_BITS'(new_len));
         write_register(REG_THRESHOLD,
                        (junk & ~field_mask(REG_THRESHOLD)) | CSR_DATA_BITS'(new_thr));
         write_register(REG_HOLDOFF,
                        (junk & ~field_mask(REG_HOLDOFF)) | CSR_DATA_BITS'(new_hold));

         // The first phase runs without any idling.
         send_idle_pct = (phase == 0) ? 0 : $urandom_range(5, 50);
         recv_stall_pct = (phase == 0) ? 0 : $urandom_range(5, 50);
         base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(256, 131071);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Steady level with spikes, plus some fully random and extreme requests.
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               vol32 = base + $urandom_range(0, base / 4 + 1);
               elapsed = TIME_BITS'($urandom_range(5, 60));
            end else if (pick < 80) begin
               vol32 = base * $urandom_range(2, 8) + $urandom_range(0, 255);
               elapsed = TIME_BITS'($urandom_range(5, 150));
            end else if (pick < 95) begin
               vol32 = $urandom() & VOL_MAX;
               elapsed = TIME_BITS'($urandom());
            end else begin
               vol32 = $urandom_range(0, 1) ? VOL_MAX : 0;
               elapsed = $urandom_range(0, 1) ? TIME_MAX : '0;
            end
            if (vol32 > VOL_MAX)
               vol32 = VOL_MAX;
            send_request(vol32[VOL_BITS-1:0], elapsed, 1'b0, 1'b0, '0);
            pause_sender();
            if ($urandom_range(0, 199) == 0)
               drain_results();
         end
      end

      drain_results();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("[energy_beat_detector] OK");
      else
         $display("[energy_beat_detector] ERROR");
      $finish;
   end

endmodule
